### design/multi_timebase_event_queue_defines.svh
// Assertion macros shared by the event queue design.
`ifndef MULTI_TIMEBASE_EVENT_QUEUE_DEFINES_SVH
`define MULTI_TIMEBASE_EVENT_QUEUE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define MTEQ_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define MTEQ_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`endif

### design/mteq_pkg.sv
// Package with types, constants and helpers of the event queue.
package mteq_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [30:0] DUE_MAX = 31'h7FFF_FFFF;
	localparam logic [1:0] PRIO_FORCED = 2'd3;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_ENQ = 2'd1,
		OP_TRANS = 2'd2,
		OP_POP = 2'd3
	} op_t;

	localparam logic [2:0] TRIG_CHOICES = 3'd0;
	localparam logic [2:0] TRIG_DAYS = 3'd1;
	localparam logic [2:0] TRIG_NIGHTS = 3'd2;
	localparam logic [2:0] TRIG_DAY_START = 3'd3;
	localparam logic [2:0] TRIG_NIGHT_START = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic is_night;
		logic [30:0] choice_count;
		logic [30:0] day_number;
		logic [30:0] night_total;
		logic [2:0] trigger_kind;
		logic [30:0] delay_offset;
		logic [1:0] priority_level;
		logic [15:0] event_tag;
	} in_item_t;

	typedef struct packed {
		logic popped_valid;
		logic [2:0] popped_trigger;
		logic [1:0] popped_priority;
		logic [15:0] popped_tag;
		logic [30:0] popped_due;
		logic forced_pending;
		logic enqueue_dropped;
		logic [4:0] entry_count;
	} out_item_t;

	typedef struct packed {
		logic [2:0] trigger;
		logic [1:0] prio;
		logic [15:0] tag;
		logic [30:0] due;
	} entry_t;

	// Control passed from the sequencer to every cell.
	typedef struct packed {
		logic shift;
		logic load;
		logic arm;
		logic arm_night;
		logic [30:0] arm_due;
	} cell_ctl_t;

	function automatic logic entry_due_now(entry_t e, logic [30:0] chc, logic [30:0] day,
			logic [30:0] ngt);
		logic r;
		case (e.trigger)
			TRIG_CHOICES, TRIG_DAY_START, TRIG_NIGHT_START: r = (chc >= e.due);
			TRIG_DAYS: r = (day >= e.due);
			TRIG_NIGHTS: r = (ngt >= e.due);
			default: r = 1'b0;
		endcase
		return r;
	endfunction
endpackage

### design/mteq_cell.sv
// One storage cell of the circulating entry ring.
module mteq_cell (
	input logic clk,
	input mteq_pkg::cell_ctl_t ctl,
	input mteq_pkg::entry_t prev_entry,
	input mteq_pkg::entry_t load_entry,
	output mteq_pkg::entry_t entry
);
	import mteq_pkg::*;

	entry_t entry_q;
	entry_t nxt;

	always_comb begin
		nxt = ctl.load ? load_entry : prev_entry;
		if (ctl.arm && nxt.trigger == (ctl.arm_night ? TRIG_NIGHT_START : TRIG_DAY_START))
			nxt.due = ctl.arm_due;
	end

	always_ff @(posedge clk) begin
		if (ctl.shift)
			entry_q <= nxt;
	end

	assign entry = entry_q;
endmodule

### design/multi_timebase_event_queue.sv
// Top level of the event queue: sequencer around a ring of storage cells.
// Each item passes from acceptance through the scan state, which rotates the ring once through all
// QUEUE_DEPTH cells, then the done state, which performs the removal, and then the result strobe.
// busy is low during the result strobe, so the next item can be accepted then, but not before.
// Reset clears the entry count and sequencer; cell contents are undefined until written.
module multi_timebase_event_queue (
	input logic clk,
	input logic arst_n,
	input logic start,
	input mteq_pkg::in_item_t in_item,
	output logic busy,
	output logic done,
	output mteq_pkg::out_item_t result
);
	import mteq_pkg::*;
	`include "multi_timebase_event_queue_defines.svh"

	state_t state_q, state_d;
	in_item_t item_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] step_q;
	logic found_q, forced_q, forced2_q, drop_q;
	logic [IDX_W-1:0] best_q;
	entry_t best_e_q, last_e_q, new_e_q;
	out_item_t result_q;
	logic [CNT_W-1:0] count_d;
	logic [CNT_W-1:0] lim_f;

	entry_t ring [QUEUE_DEPTH];
	cell_ctl_t ctl;
	cell_ctl_t cctl [QUEUE_DEPTH];
	entry_t head;
	entry_t load_e;
	entry_t feed;
	logic [IDX_W-1:0] pos;
	logic in_range, head_due, in_f, feed_due, swap, forced_after;
	logic [31:0] sum;
	logic [30:0] base;

	// Cell 0 sees position step_q of the queue at the head of each scan cycle.
	assign head = ring[QUEUE_DEPTH-1];
	assign pos = step_q;
	assign in_range = ({1'b0, pos} < count_q);
	assign head_due = entry_due_now(head, item_q.choice_count, item_q.day_number,
		item_q.night_total);

	always_comb begin
		case (in_item.trigger_kind)
			TRIG_CHOICES: base = in_item.choice_count;
			TRIG_DAYS: base = in_item.day_number;
			default: base = in_item.night_total;
		endcase
		sum = {1'b0, base} + {1'b0, in_item.delay_offset};
	end

	always_comb begin
		ctl = '0;
		ctl.arm_night = item_q.is_night;
		ctl.arm_due = item_q.choice_count;
		ctl.shift = (state_q == ST_SCAN);
		if (state_q == ST_SCAN) begin
			if (item_q.op == OP_ENQ && !drop_q && {1'b0, pos} == count_q)
				ctl.load = 1'b1;
			ctl.arm = (item_q.op == OP_TRANS) && in_range;
		end
		swap = (state_q == ST_DONE) && (item_q.op == OP_POP) && found_q;
		load_e = (state_q == ST_DONE) ? last_e_q : new_e_q;
		for (int k = 0; k < QUEUE_DEPTH; k++) begin
			cctl[k] = '0;
			cctl[k].shift = ctl.shift;
			if (k == 0)
				cctl[k] = ctl;
			if (swap && best_q == IDX_W'(QUEUE_DEPTH - 1 - k)) begin
				cctl[k].shift = 1'b1;
				cctl[k].load = 1'b1;
			end
		end
	end

	// Entry entering cell 0, after any load or arming.
	always_comb begin
		feed = ctl.load ? new_e_q : head;
		if (ctl.arm && feed.trigger == (ctl.arm_night ? TRIG_NIGHT_START : TRIG_DAY_START))
			feed.due = ctl.arm_due;
	end

	assign feed_due = entry_due_now(feed, item_q.choice_count, item_q.day_number,
		item_q.night_total);
	assign lim_f = (item_q.op == OP_POP) ? count_q : count_d;
	assign in_f = ({1'b0, pos} < lim_f);

	generate
		for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
			mteq_cell u_cell (
				.clk(clk),
				.ctl(cctl[g]),
				.prev_entry(g == 0 ? head : ring[(g == 0) ? 0 : g-1]),
				.load_entry(load_e),
				.entry(ring[g])
			);
		end
	endgenerate

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (start) state_d = ST_SCAN;
			ST_SCAN: if (step_q == IDX_W'(QUEUE_DEPTH-1)) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			state_q <= state_d;
			done <= 1'b0;
			if (state_q == ST_IDLE)
				step_q <= '0;
			else if (state_q == ST_SCAN)
				step_q <= step_q + 1'b1;
			if (state_q == ST_DONE) begin
				count_q <= count_d;
				done <= 1'b1;
			end
		end
	end

	always_comb begin
		count_d = count_q;
		unique case (op_t'(item_q.op))
			OP_CLEAR: count_d = '0;
			OP_ENQ: if (!drop_q) count_d = count_q + 1'b1;
			OP_POP: if (found_q) count_d = count_q - 1'b1;
			default: count_d = count_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			item_q <= in_item;
			drop_q <= (count_q >= CNT_W'(QUEUE_DEPTH));
			found_q <= 1'b0;
			forced_q <= 1'b0;
			forced2_q <= 1'b0;
			new_e_q.trigger <= in_item.trigger_kind;
			new_e_q.prio <= in_item.priority_level;
			new_e_q.tag <= in_item.event_tag;
			if (in_item.trigger_kind <= TRIG_NIGHTS)
				new_e_q.due <= sum[31] ? DUE_MAX : sum[30:0];
			else
				new_e_q.due <= DUE_MAX;
		end else if (state_q == ST_SCAN) begin
			if (in_range && head_due && item_q.op == OP_POP
					&& (!found_q || head.prio > best_e_q.prio)) begin
				found_q <= 1'b1;
				best_q <= pos;
				best_e_q <= head;
			end
			if ({1'b0, pos} == count_q - 1'b1)
				last_e_q <= head;
			if (in_f && feed_due && feed.prio == PRIO_FORCED) begin
				forced_q <= 1'b1;
				if (forced_q)
					forced2_q <= 1'b1;
			end
		end
	end

	// A popped entry is the first forced one whenever any forced entry is due.
	assign forced_after = (item_q.op == OP_POP && found_q) ? forced2_q : forced_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE) begin
			result_q.popped_valid <= (item_q.op == OP_POP) && found_q;
			result_q.popped_trigger <= (item_q.op == OP_POP && found_q) ? best_e_q.trigger : '0;
			result_q.popped_priority <= (item_q.op == OP_POP && found_q) ? best_e_q.prio : '0;
			result_q.popped_tag <= (item_q.op == OP_POP && found_q) ? best_e_q.tag : '0;
			result_q.popped_due <= (item_q.op == OP_POP && found_q) ? best_e_q.due : '0;
			result_q.forced_pending <= forced_after;
			result_q.enqueue_dropped <= (item_q.op == OP_ENQ) && drop_q;
			result_q.entry_count <= 5'(count_d);
		end
	end

	assign result = result_q;

	`MTEQ_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH))
	`MTEQ_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy)
	`MTEQ_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
endmodule

### sim/mteq_checker.sv
// Checker for the event queue: predicts every result from the accepted items and compares.
module mteq_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input mteq_pkg::in_item_t in_item,
	input mteq_pkg::out_item_t result,
	output int errors,
	output int pending
);
	import mteq_pkg::*;

	entry_t slots [QUEUE_DEPTH];
	int held;
	out_item_t awaited [$];

	function automatic logic slot_due(entry_t e, logic [30:0] chc, logic [30:0] day,
			logic [30:0] ngt);
		logic r;
		case (e.trigger)
			TRIG_CHOICES, TRIG_DAY_START, TRIG_NIGHT_START: r = (chc >= e.due);
			TRIG_DAYS: r = (day >= e.due);
			TRIG_NIGHTS: r = (ngt >= e.due);
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic [30:0] add_clamped(logic [30:0] a, logic [30:0] b);
		logic [31:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[31] ? DUE_MAX : s[30:0];
	endfunction

	function automatic out_item_t next_result(in_item_t it);
		out_item_t r;
		entry_t e;
		int best;
		logic [2:0] want;
		r = '0;
		best = -1;
		case (op_t'(it.op))
			OP_CLEAR: held = 0;
			OP_ENQ: begin
				if (held >= QUEUE_DEPTH) begin
					r.enqueue_dropped = 1'b1;
				end else begin
					e.trigger = it.trigger_kind;
					e.prio = it.priority_level;
					e.tag = it.event_tag;
					case (it.trigger_kind)
						TRIG_CHOICES: e.due = add_clamped(it.choice_count, it.delay_offset);
						TRIG_DAYS: e.due = add_clamped(it.day_number, it.delay_offset);
						TRIG_NIGHTS: e.due = add_clamped(it.night_total, it.delay_offset);
						default: e.due = DUE_MAX;
					endcase
					slots[held] = e;
					held++;
				end
			end
			OP_TRANS: begin
				want = it.is_night ? TRIG_NIGHT_START : TRIG_DAY_START;
				for (int i = 0; i < held; i++)
					if (slots[i].trigger == want) slots[i].due = it.choice_count;
			end
			default: begin
				for (int i = 0; i < held; i++)
					if (slot_due(slots[i], it.choice_count, it.day_number, it.night_total) &&
							(best < 0 || slots[i].prio > slots[best].prio))
						best = i;
				if (best >= 0) begin
					r.popped_valid = 1'b1;
					r.popped_trigger = slots[best].trigger;
					r.popped_priority = slots[best].prio;
					r.popped_tag = slots[best].tag;
					r.popped_due = slots[best].due;
					slots[best] = slots[held - 1];
					held--;
				end
			end
		endcase
		for (int i = 0; i < held; i++)
			if (slots[i].prio == PRIO_FORCED &&
					slot_due(slots[i], it.choice_count, it.day_number, it.night_total))
				r.forced_pending = 1'b1;
		r.entry_count = held[4:0];
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t w;
		if (!arst_n) begin
			held = 0;
			errors = 0;
			awaited.delete();
		end else begin
			if (done) begin
				if (awaited.size() == 0) begin
					$display("%0t: result with no item outstanding, got %h", $time, result);
					errors++;
				end else begin
					w = awaited.pop_front();
					check_field("popped_valid", 32'(w.popped_valid),
						32'(result.popped_valid));
					check_field("popped_trigger", 32'(w.popped_trigger),
						32'(result.popped_trigger));
					check_field("popped_priority", 32'(w.popped_priority),
						32'(result.popped_priority));
					check_field("popped_tag", 32'(w.popped_tag), 32'(result.popped_tag));
					check_field("popped_due", 32'(w.popped_due), 32'(result.popped_due));
					check_field("forced_pending", 32'(w.forced_pending),
						32'(result.forced_pending));
					check_field("enqueue_dropped", 32'(w.enqueue_dropped),
						32'(result.enqueue_dropped));
					check_field("entry_count", 32'(w.entry_count), 32'(result.entry_count));
				end
			end
			if (start && !busy) awaited.push_back(next_result(in_item));
		end
		pending = awaited.size();
	end
endmodule

### sim/tb_multi_timebase_event_queue.sv
// Testbench top of the event queue: stimulus, watchdog and verdict.
module tb_multi_timebase_event_queue;
	import mteq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	in_item_t in_item = '0;
	logic busy, done;
	out_item_t result;
	int errors, pending;
	int stall_cycles = 0;
	int quiet_run = 0;
	logic [30:0] base_now = '0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	multi_timebase_event_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .in_item(in_item),
		.busy(busy), .done(done), .result(result)
	);

	mteq_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.in_item(in_item), .result(result), .errors(errors), .pending(pending)
	);

	always @(posedge clk) begin
		if ((start && !busy) || done) stall_cycles <= 0;
		else stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= 5000) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic send(in_item_t it);
		int gap;
		logic b;
		gap = (quiet_run > 0) ? 0 : $urandom_range(0, 16);
		if (quiet_run > 0) quiet_run--;
		else if ($urandom_range(0, 30) == 0) quiet_run = 20;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		in_item <= it;
		do begin
			@(negedge clk);
			b = busy;
			@(posedge clk);
		end while (b);
	endtask

	function automatic in_item_t make_item(op_t op, logic [2:0] kind, logic [30:0] chc,
			logic [30:0] day, logic [30:0] ngt, logic [30:0] offs, logic [1:0] prio,
			logic [15:0] tag, logic night);
		in_item_t it;
		it.op = op;
		it.is_night = night;
		it.choice_count = chc;
		it.day_number = day;
		it.night_total = ngt;
		it.trigger_kind = kind;
		it.delay_offset = offs;
		it.priority_level = prio;
		it.event_tag = tag;
		return it;
	endfunction

	function automatic logic [30:0] near_now();
		if ($urandom_range(0, 9) == 0) return 31'($urandom());
		return 31'(base_now + $urandom_range(0, 40));
	endfunction

	function automatic in_item_t random_item();
		in_item_t it;
		int pick;
		pick = $urandom_range(0, 99);
		it.op = (pick < 3) ? OP_CLEAR : (pick < 45) ? OP_ENQ : (pick < 60) ? OP_TRANS : OP_POP;
		it.is_night = 1'($urandom_range(0, 1));
		it.choice_count = near_now();
		it.day_number = near_now();
		it.night_total = near_now();
		it.trigger_kind = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7)) :
			3'($urandom_range(0, 4));
		it.delay_offset = ($urandom_range(0, 7) == 0) ? 31'($urandom()) :
			31'($urandom_range(0, 30));
		it.priority_level = 2'($urandom_range(0, 3));
		it.event_tag = 16'($urandom());
		return it;
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send(make_item(OP_POP, TRIG_CHOICES, DUE_MAX, DUE_MAX, DUE_MAX, 0, 0, 0, 0));
		send(make_item(OP_ENQ, TRIG_CHOICES, DUE_MAX, 0, 0, DUE_MAX, PRIO_FORCED, 16'hFFFF, 1));
		send(make_item(OP_ENQ, TRIG_DAYS, 0, 31'd100, 0, 31'd5, 2'd2, 16'h0001, 0));
		send(make_item(OP_ENQ, TRIG_NIGHTS, 0, 0, 31'd7, 0, 2'd1, 16'h0002, 0));
		send(make_item(OP_ENQ, TRIG_DAY_START, 31'd3, 0, 0, 31'd9, PRIO_FORCED, 16'h0003, 0));
		send(make_item(OP_ENQ, TRIG_NIGHT_START, 31'd3, 0, 0, 31'd9, 2'd0, 16'h0004, 0));
		send(make_item(OP_ENQ, 3'd5, 0, 0, 0, 0, PRIO_FORCED, 16'h0005, 0));
		send(make_item(OP_ENQ, 3'd6, 0, 0, 0, 0, 2'd1, 16'h0006, 0));
		send(make_item(OP_ENQ, 3'd7, 0, 0, 0, 0, 2'd2, 16'h0007, 0));
		send(make_item(OP_POP, TRIG_CHOICES, 31'd50, 31'd104, 31'd6, 0, 0, 0, 0));
		send(make_item(OP_TRANS, TRIG_CHOICES, 31'd20, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_TRANS, TRIG_CHOICES, 31'd25, 0, 0, 0, 0, 0, 1));
		send(make_item(OP_POP, TRIG_CHOICES, 31'd30, 31'd200, 31'd7, 0, 0, 0, 0));
		send(make_item(OP_POP, TRIG_CHOICES, 31'd30, 31'd200, 31'd7, 0, 0, 0, 0));
		send(make_item(OP_POP, TRIG_CHOICES, DUE_MAX, DUE_MAX, DUE_MAX, 0, 0, 0, 0));
		for (int i = 0; i < 10; i++)
			send(make_item(OP_ENQ, TRIG_CHOICES, 0, 0, 0, 31'(i), i[1:0], i[15:0], 0));
		send(make_item(OP_ENQ, TRIG_DAYS, 0, 0, 0, 0, 2'd3, 16'hAAAA, 0));
		send(make_item(OP_POP, TRIG_CHOICES, 31'd4, 0, 0, 0, 0, 0, 0));
		send(make_item(OP_CLEAR, 3'd7, DUE_MAX, DUE_MAX, DUE_MAX, DUE_MAX, 2'd3, 16'hFFFF, 1));
		for (int i = 0; i < 400; i++) begin
			if ($urandom_range(0, 3) == 0) base_now = 31'(base_now + $urandom_range(0, 12));
			send(random_item());
		end
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0) $display("CHECK OK");
		else $display("CHECK FAILED");
		$finish;
	end
endmodule

### filelist.f
+incdir+design
design/mteq_pkg.sv
design/mteq_cell.sv
design/multi_timebase_event_queue.sv
sim/mteq_checker.sv
sim/tb_multi_timebase_event_queue.sv
